@@ hw/rtl/atan2ba_pkg.sv @@
// ----------------------------------------------------------------------------
// atan2ba_pkg
// Shared constants, types and the arctangent table for the binary-angle
// atan2 pipeline.
// ----------------------------------------------------------------------------
package atan2ba_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // CORDIC chain
    localparam int CORDIC_STEPS = 30;
    localparam int PRE_SHIFT    = 30;

    // Fold register, cell chain, unfold register
    localparam int LATENCY = CORDIC_STEPS + 2;

    // Turn fractions in 2^-32 turn
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;

    // Per-item control that travels with the data down the chain
    typedef struct packed {
        logic valid;
        logic swap;        // |vert| > |horiz|, octant angle mirrored
        logic h_neg;
        logic v_neg;
        logic zero_small;  // smaller magnitude is zero, octant angle is 0
    } stage_ctl_t;

    // atan(2^-idx) in 2^-32 turn
    function automatic logic [31:0] atan_tab(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'h2000_0000;
            1:       val = 32'h12E4_051E;
            2:       val = 32'h09FB_385B;
            3:       val = 32'h0511_11D4;
            4:       val = 32'h028B_0D43;
            5:       val = 32'h0145_D7E1;
            6:       val = 32'h00A2_F61E;
            7:       val = 32'h0051_7C55;
            8:       val = 32'h0028_BE53;
            9:       val = 32'h0014_5F2F;
            10:      val = 32'h000A_2F98;
            11:      val = 32'h0005_17CC;
            12:      val = 32'h0002_8BE6;
            13:      val = 32'h0001_45F3;
            14:      val = 32'h0000_A2FA;
            15:      val = 32'h0000_517D;
            16:      val = 32'h0000_28BE;
            17:      val = 32'h0000_145F;
            18:      val = 32'h0000_0A30;
            19:      val = 32'h0000_0518;
            20:      val = 32'h0000_028C;
            21:      val = 32'h0000_0146;
            22:      val = 32'h0000_00A3;
            23:      val = 32'h0000_0051;
            24:      val = 32'h0000_0029;
            25:      val = 32'h0000_0014;
            26:      val = 32'h0000_000A;
            27:      val = 32'h0000_0005;
            28:      val = 32'h0000_0003;
            29:      val = 32'h0000_0001;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/atan2_binary_angle.sv @@
// ----------------------------------------------------------------------------
// atan2_binary_angle
// Direction of a signed 2-D vector as a binary angle, 2^ANGLE_BITS units per
// turn, counter-clockwise from the positive horizontal axis.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle: busy stays low and an item is
// accepted at each edge where start is high. Its angle appears on the angle
// port with done high for exactly one cycle, after it has passed the octant
// fold register, each of the 30 CORDIC cells of the chain, and the output
// rounding register in turn. Results leave in the order items came in and
// cannot be held off, so the receiver must take done/angle in the cycle
// they are shown. A zero vector gives angle 0.
// ----------------------------------------------------------------------------
module atan2_binary_angle #(
    parameter int COORD_BITS = atan2ba_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = atan2ba_pkg::ANGLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COORD_BITS-1:0]   horiz_coord,
    input  logic [COORD_BITS-1:0]   vert_coord,
    output logic                    done,
    output logic [ANGLE_BITS-1:0]   angle
);

    localparam int XW    = COORD_BITS + atan2ba_pkg::PRE_SHIFT + 2;
    localparam int STEPS = atan2ba_pkg::CORDIC_STEPS;

    atan2ba_pkg::stage_ctl_t  ctl_s [STEPS+1];
    logic signed [XW-1:0]     x_s   [STEPS+1];
    logic signed [XW-1:0]     y_s   [STEPS+1];
    logic [31:0]              z_s   [STEPS+1];

    // Pipeline never stalls
    assign busy = 1'b0;

    // Octant fold
    atan2ba_fold #(
        .COORD_BITS (COORD_BITS),
        .XW         (XW)
    ) u_fold (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (start && !busy),
        .horiz_coord (horiz_coord),
        .vert_coord  (vert_coord),
        .ctl_out     (ctl_s[0]),
        .x_out       (x_s[0]),
        .y_out       (y_s[0]),
        .z_out       (z_s[0])
    );

    // CORDIC cell chain
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        atan2ba_cell #(
            .STEP (i),
            .XW   (XW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_s[i]),
            .x_in    (x_s[i]),
            .y_in    (y_s[i]),
            .z_in    (z_s[i]),
            .ctl_out (ctl_s[i+1]),
            .x_out   (x_s[i+1]),
            .y_out   (y_s[i+1]),
            .z_out   (z_s[i+1])
        );
    end

    // Unfold and round
    atan2ba_unfold #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_unfold (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl_s[STEPS]),
        .z_in   (z_s[STEPS]),
        .done   (done),
        .angle  (angle)
    );

endmodule

@@ hw/rtl/atan2ba_fold.sv @@
// ----------------------------------------------------------------------------
// atan2ba_fold
// Input cell: takes magnitudes, folds the vector into the first octant and
// loads the first CORDIC cell.
// ----------------------------------------------------------------------------
module atan2ba_fold #(
    parameter int COORD_BITS = atan2ba_pkg::COORD_BITS_DEF,
    parameter int XW         = COORD_BITS + atan2ba_pkg::PRE_SHIFT + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [COORD_BITS-1:0]         horiz_coord,
    input  logic [COORD_BITS-1:0]         vert_coord,
    output atan2ba_pkg::stage_ctl_t       ctl_out,
    output logic signed [XW-1:0]          x_out,
    output logic signed [XW-1:0]          y_out,
    output logic [31:0]                   z_out
);

    logic                     h_neg, v_neg, swap;
    logic [COORD_BITS-1:0]    mag_h, mag_v, big, small_mag;

    atan2ba_pkg::stage_ctl_t  ctl_reg, ctl_next;
    logic signed [XW-1:0]     x_reg, x_next, y_reg, y_next;

    // Magnitudes; the most negative code maps to 2^(COORD_BITS-1) unsigned
    always_comb
    begin
        h_neg     = horiz_coord[COORD_BITS-1];
        v_neg     = vert_coord[COORD_BITS-1];
        mag_h     = h_neg ? (~horiz_coord + 1'b1) : horiz_coord;
        mag_v     = v_neg ? (~vert_coord + 1'b1) : vert_coord;
        swap      = (mag_v > mag_h);
        big       = swap ? mag_v : mag_h;
        small_mag = swap ? mag_h : mag_v;
    end

    // Next cell contents
    always_comb
    begin
        ctl_next.valid      = load;
        ctl_next.swap       = swap;
        ctl_next.h_neg      = h_neg;
        ctl_next.v_neg      = v_neg;
        ctl_next.zero_small = (small_mag == '0);
        x_next = {2'b00, big, {atan2ba_pkg::PRE_SHIFT{1'b0}}};
        y_next = {2'b00, small_mag, {atan2ba_pkg::PRE_SHIFT{1'b0}}};
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = '0;

endmodule

@@ hw/rtl/atan2ba_cell.sv @@
// ----------------------------------------------------------------------------
// atan2ba_cell
// One CORDIC vectoring step: rotate toward the x axis by atan(2^-STEP) and
// accumulate the rotation angle.
// ----------------------------------------------------------------------------
module atan2ba_cell #(
    parameter int STEP = 0,
    parameter int XW   = atan2ba_pkg::COORD_BITS_DEF + atan2ba_pkg::PRE_SHIFT + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  atan2ba_pkg::stage_ctl_t  ctl_in,
    input  logic signed [XW-1:0]     x_in,
    input  logic signed [XW-1:0]     y_in,
    input  logic [31:0]              z_in,
    output atan2ba_pkg::stage_ctl_t  ctl_out,
    output logic signed [XW-1:0]     x_out,
    output logic signed [XW-1:0]     y_out,
    output logic [31:0]              z_out
);

    localparam logic [31:0] STEP_ANGLE = atan2ba_pkg::atan_tab(STEP);

    logic signed [XW-1:0]     dx, dy;
    logic signed [XW-1:0]     x_reg, x_next, y_reg, y_next;
    logic [31:0]              z_reg, z_next;
    atan2ba_pkg::stage_ctl_t  ctl_reg;

    // Rotation direction follows the sign of y; both updates use old x, y
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[XW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + STEP_ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - STEP_ANGLE;
        end
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

@@ hw/rtl/atan2ba_unfold.sv @@
// ----------------------------------------------------------------------------
// atan2ba_unfold
// Output cell: maps the octant angle back to the full circle, rounds to
// ANGLE_BITS and raises the result strobe.
// ----------------------------------------------------------------------------
module atan2ba_unfold #(
    parameter int ANGLE_BITS = atan2ba_pkg::ANGLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  atan2ba_pkg::stage_ctl_t  ctl_in,
    input  logic [31:0]              z_in,
    output logic                     done,
    output logic [ANGLE_BITS-1:0]    angle
);

    // Quadrant codes {h_neg, v_neg}
    localparam logic [1:0] QUAD_I   = 2'b00;
    localparam logic [1:0] QUAD_II  = 2'b10;
    localparam logic [1:0] QUAD_III = 2'b11;
    localparam logic [1:0] QUAD_IV  = 2'b01;

    localparam logic [31:0] ROUND_HALF = 32'(1) << (31 - ANGLE_BITS);

    logic [31:0]            octant, phi, full, rounded;
    logic                   done_reg, done_next;
    logic [ANGLE_BITS-1:0]  angle_reg, angle_next;

    // Unfold and round
    always_comb
    begin
        octant = ctl_in.zero_small ? 32'h0 : z_in;
        phi    = ctl_in.swap ? (atan2ba_pkg::TURN_QUARTER - octant) : octant;
        case ({ctl_in.h_neg, ctl_in.v_neg})
            QUAD_I:   full = phi;
            QUAD_II:  full = atan2ba_pkg::TURN_HALF - phi;
            QUAD_III: full = atan2ba_pkg::TURN_HALF + phi;
            QUAD_IV:  full = 32'h0 - phi;
            default:  full = phi;
        endcase
        rounded    = full + ROUND_HALF;
        angle_next = rounded[31 -: ANGLE_BITS];
        done_next  = ctl_in.valid;
    end

    // Strobe register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

@@ hw/rtl/atan2ba_checker.sv @@
// ----------------------------------------------------------------------------
// atan2ba_checker
// Port-level checks on the atan2 pipeline: fixed latency, one result per
// item, and exact axis directions.
// ----------------------------------------------------------------------------
module atan2ba_checker #(
    parameter int COORD_BITS = atan2ba_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = atan2ba_pkg::ANGLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [COORD_BITS-1:0]  horiz_coord,
    input  logic [COORD_BITS-1:0]  vert_coord,
    input  logic                   done,
    input  logic [ANGLE_BITS-1:0]  angle
);

    localparam int LAT = atan2ba_pkg::LATENCY;

    // Every accepted item yields a strobe after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("no result strobe at fixed latency after an item");

    // No strobe without an item accepted the fixed latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without matching item");

    // Positive horizontal axis gives angle zero
    a_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && vert_coord == '0 && !horiz_coord[COORD_BITS-1])
        |-> ##LAT (angle == '0))
        else $error("positive horizontal axis not at angle zero");

    // Positive vertical axis gives a quarter turn
    a_axis_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && horiz_coord == '0 && !vert_coord[COORD_BITS-1]
            && vert_coord != '0)
        |-> ##LAT (angle == ANGLE_BITS'(1) << (ANGLE_BITS - 2)))
        else $error("positive vertical axis not at a quarter turn");

endmodule

bind atan2_binary_angle atan2ba_checker #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
) u_atan2ba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .horiz_coord (horiz_coord),
    .vert_coord  (vert_coord),
    .done        (done),
    .angle       (angle)
);
